### rtl/core/ate_pkg.sv
// Shared package for the autocorrelation tempo estimator.
// Holds widths, reset values, register and status codes and the sequencer state type.
// No dependencies.
package ate_pkg;

  // Default sizes for the top-level parameters.
  localparam int MAX_SAMPLES_DEF = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  // Fixed field widths.
  localparam int RATE_W    = 16;
  localparam int BPM_W     = 10;
  localparam int STATUS_W  = 3;
  localparam int OUT_W     = 16;
  localparam int LAG_W     = 10;
  localparam int CFG_IDX_W = 2;
  // 60 * rate fits in 22 bits, 240 * rate in 24 bits.
  localparam int WIN_W     = 22;
  localparam int TEMPO_W   = 24;

  // Configuration reset values.
  localparam logic [RATE_W-1:0] RATE_RST = 16'd1376;
  localparam logic [BPM_W-1:0]  MIN_RST  = 10'd60;
  localparam logic [BPM_W-1:0]  MAX_RST  = 10'd200;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX  = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FEW   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_CFG   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOEN  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;
  localparam logic [STATUS_W-1:0] ST_WEAK  = 3'd5;

  localparam int MIN_SAMPLES = 8;
  localparam int SEC_PER_MIN = 60;
  localparam int TEMPO_MUL   = 240;
  localparam int WEAK_MUL    = 100;
  localparam logic [OUT_W-1:0] OUT_MAX = 16'hFFFF;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_LOAD, S_CHECK, S_DIV, S_MEAN,
    S_EN_A, S_EN_B, S_EN_C, S_EN_D, S_EN_CHK,
    S_LO, S_WIN,
    S_AC_A, S_AC_B, S_AC_C, S_AC_D, S_AC_NEXT,
    S_PEAK, S_TEMPO, S_CONF, S_OUT
  } ate_state_t;

endpackage

### rtl/core/ate_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ate_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/autocorrelation_tempo_estimator.sv
// Autocorrelation tempo estimator: loads a curve, one sample per cycle, then searches lags.
// After the last sample it runs up to five bit-serial divisions with quotients of
// 2*SAMPLE_BITS+log2(MAX_SAMPLES)+16 bits, an energy pass over the samples, a correlation
// pass per searched lag and the sequencing states. Samples are taken one per cycle while loading;
// a new curve waits until the result has been taken.
// rst_n is synchronous, active low; it clears control state and restores config defaults.
// Depends on ate_pkg and ate_ram.
module autocorrelation_tempo_estimator #(
  parameter int MAX_SAMPLES = ate_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = ate_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [SAMPLE_BITS-1:0]      in_onset_value,
  input  logic                               in_last_sample,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ate_pkg::STATUS_W-1:0]       out_status,
  output logic [ate_pkg::OUT_W-1:0]          out_tempo_bpm_q6,
  output logic [ate_pkg::OUT_W-1:0]          out_confidence_q16,
  output logic [ate_pkg::LAG_W-1:0]          out_best_lag,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ate_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ate_pkg::RATE_W-1:0]         cfg_data
);

  localparam int SB   = SAMPLE_BITS;
  localparam int AW   = $clog2(MAX_SAMPLES);
  localparam int CW   = $clog2(MAX_SAMPLES + 1);
  localparam int SW   = SB + AW + 1;
  localparam int EW   = 2 * SB + AW;
  localparam int DW   = EW + 16;
  localparam int DCW  = $clog2(DW + 1);
  localparam int PW   = EW + 7;
  localparam int WW   = ate_pkg::WIN_W;
  localparam int TW   = ate_pkg::TEMPO_W;
  localparam int BW   = ate_pkg::BPM_W;

  ate_pkg::ate_state_t state_r, state_nxt, ret_r, ret_nxt;

  logic [ate_pkg::RATE_W-1:0] rate_r, rate_nxt;
  logic [BW-1:0]              min_r, min_nxt, max_r, max_nxt;

  logic [CW-1:0]              count_r, count_nxt;
  logic signed [SW-1:0]       sum_r, sum_nxt;
  logic [EW-1:0]              energy_r, energy_nxt;
  logic [EW-1:0]              acc_r, acc_nxt;
  logic [EW-1:0]              best_r, best_nxt;
  logic [CW-1:0]              best_lag_r, best_lag_nxt;
  logic [CW-1:0]              idx_r, idx_nxt;
  logic [CW-1:0]              lag_r, lag_nxt;
  logic [CW-1:0]              hi_r, hi_nxt;
  logic [WW-1:0]              lo_r, lo_nxt;
  logic signed [SB:0]         mean_r, mean_nxt;
  logic [SB-1:0]              a_r, a_nxt;
  logic [2*SB-1:0]            prod_r, prod_nxt;

  logic [DW-1:0]              dquo_r, dquo_nxt;
  logic [EW:0]                drem_r, drem_nxt;
  logic [EW-1:0]              dden_r, dden_nxt;
  logic [DCW-1:0]             dcnt_r, dcnt_nxt;

  logic [ate_pkg::STATUS_W-1:0] ost_r, ost_nxt;
  logic [ate_pkg::OUT_W-1:0]    otempo_r, otempo_nxt, oconf_r, oconf_nxt;
  logic [ate_pkg::LAG_W-1:0]    olag_r, olag_nxt;

  logic                       in_acc, out_acc, last_n, bad_cfg;
  logic                       ram_we;
  logic [AW-1:0]              raddr;
  logic [SB-1:0]              rdata;
  logic signed [SB+1:0]       diff;
  logic [SB-1:0]              rect_v, mul_b;
  logic [EW:0]                rem_sh;
  logic                       rem_ge;
  logic                       rem_nz;
  logic [WW-1:0]              hi_raw, hi_clamp, n_m1;
  logic [PW-1:0]              best_x100;
  logic                       run_clear;

  // Handshakes.
  assign in_stall  = (state_r != ate_pkg::S_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (state_r == ate_pkg::S_OUT);
  assign out_acc   = out_valid && !out_stall;
  assign cfg_ready = 1'b1;

  assign out_status         = ost_r;
  assign out_tempo_bpm_q6   = otempo_r;
  assign out_confidence_q16 = oconf_r;
  assign out_best_lag       = olag_r;

  // Sample store.
  assign ram_we = in_acc && (count_r < CW'(MAX_SAMPLES));

  ate_ram #(
    .WIDTH(SB),
    .DEPTH(MAX_SAMPLES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (in_onset_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Read address: second operand of a lag product sits lag samples back.
  always_comb begin
    raddr = idx_r[AW-1:0];
    if (state_r == ate_pkg::S_AC_B) begin
      raddr = AW'(idx_r - lag_r);
    end
  end

  // Half-wave rectified sample minus mean, and the shared multiplier operand.
  assign diff   = (SB+2)'($signed(rdata)) - (SB+2)'(mean_r);
  assign rect_v = (diff > 0) ? diff[SB-1:0] : '0;
  assign mul_b  = (state_r == ate_pkg::S_AC_C) ? rect_v : a_r;

  // Divider step and common terms.
  assign rem_sh    = {drem_r[EW-1:0], dquo_r[DW-1]};
  assign rem_ge    = (rem_sh >= {1'b0, dden_r});
  assign rem_nz    = (drem_r != '0);
  assign n_m1      = WW'(count_r) - WW'(1);
  assign hi_raw    = dquo_r[WW-1:0] + WW'(rem_nz);
  assign hi_clamp  = (hi_raw > n_m1) ? n_m1 : hi_raw;
  assign best_x100 = PW'(best_r) * PW'(ate_pkg::WEAK_MUL);
  assign last_n    = (idx_r == CW'(n_m1));
  assign bad_cfg   = (rate_r == '0) || (min_r == '0) || (max_r <= min_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    unique case (state_r)
      ate_pkg::S_LOAD: begin
        if (in_acc && in_last_sample) state_nxt = ate_pkg::S_CHECK;
      end
      ate_pkg::S_CHECK: begin
        if (count_r < CW'(ate_pkg::MIN_SAMPLES) || bad_cfg) begin
          state_nxt = ate_pkg::S_OUT;
        end else begin
          state_nxt = ate_pkg::S_DIV;
          ret_nxt   = ate_pkg::S_MEAN;
        end
      end
      ate_pkg::S_DIV: begin
        if (dcnt_r == DCW'(1)) state_nxt = ret_r;
      end
      ate_pkg::S_MEAN:  state_nxt = ate_pkg::S_EN_A;
      ate_pkg::S_EN_A:  state_nxt = ate_pkg::S_EN_B;
      ate_pkg::S_EN_B:  state_nxt = ate_pkg::S_EN_C;
      ate_pkg::S_EN_C:  state_nxt = ate_pkg::S_EN_D;
      ate_pkg::S_EN_D:  state_nxt = last_n ? ate_pkg::S_EN_CHK : ate_pkg::S_EN_A;
      ate_pkg::S_EN_CHK: begin
        if (energy_r == '0) begin
          state_nxt = ate_pkg::S_OUT;
        end else begin
          state_nxt = ate_pkg::S_DIV;
          ret_nxt   = ate_pkg::S_LO;
        end
      end
      ate_pkg::S_LO: begin
        state_nxt = ate_pkg::S_DIV;
        ret_nxt   = ate_pkg::S_WIN;
      end
      ate_pkg::S_WIN: begin
        state_nxt = (hi_clamp <= lo_r) ? ate_pkg::S_OUT : ate_pkg::S_AC_A;
      end
      ate_pkg::S_AC_A:  state_nxt = ate_pkg::S_AC_B;
      ate_pkg::S_AC_B:  state_nxt = ate_pkg::S_AC_C;
      ate_pkg::S_AC_C:  state_nxt = ate_pkg::S_AC_D;
      ate_pkg::S_AC_D:  state_nxt = last_n ? ate_pkg::S_AC_NEXT : ate_pkg::S_AC_A;
      ate_pkg::S_AC_NEXT: begin
        state_nxt = (lag_r == hi_r) ? ate_pkg::S_PEAK : ate_pkg::S_AC_A;
      end
      ate_pkg::S_PEAK: begin
        if (best_lag_r == '0 || best_x100 <= PW'(energy_r)) begin
          state_nxt = ate_pkg::S_OUT;
        end else begin
          state_nxt = ate_pkg::S_DIV;
          ret_nxt   = ate_pkg::S_TEMPO;
        end
      end
      ate_pkg::S_TEMPO: begin
        state_nxt = ate_pkg::S_DIV;
        ret_nxt   = ate_pkg::S_CONF;
      end
      ate_pkg::S_CONF:  state_nxt = ate_pkg::S_OUT;
      ate_pkg::S_OUT: begin
        if (out_acc) state_nxt = ate_pkg::S_LOAD;
      end
      default: state_nxt = ate_pkg::S_LOAD;
    endcase
  end

  // Datapath next values.
  always_comb begin
    rate_nxt     = rate_r;
    min_nxt      = min_r;
    max_nxt      = max_r;
    count_nxt    = count_r;
    sum_nxt      = sum_r;
    energy_nxt   = energy_r;
    acc_nxt      = acc_r;
    best_nxt     = best_r;
    best_lag_nxt = best_lag_r;
    idx_nxt      = idx_r;
    lag_nxt      = lag_r;
    hi_nxt       = hi_r;
    lo_nxt       = lo_r;
    mean_nxt     = mean_r;
    a_nxt        = a_r;
    prod_nxt     = a_r * mul_b;
    dquo_nxt     = dquo_r;
    drem_nxt     = drem_r;
    dden_nxt     = dden_r;
    dcnt_nxt     = dcnt_r;
    ost_nxt      = ost_r;
    otempo_nxt   = otempo_r;
    oconf_nxt    = oconf_r;
    olag_nxt     = olag_r;
    run_clear    = 1'b0;

    // Configuration writes.
    if (cfg_valid) begin
      unique case (cfg_index)
        ate_pkg::REG_RATE: rate_nxt = cfg_data;
        ate_pkg::REG_MIN:  min_nxt  = cfg_data[BW-1:0];
        ate_pkg::REG_MAX:  max_nxt  = cfg_data[BW-1:0];
        default: ;
      endcase
    end

    case (state_r)
      // Store samples and keep the running sum.
      ate_pkg::S_LOAD: begin
        if (ram_we) begin
          count_nxt = count_r + CW'(1);
          sum_nxt   = sum_r + SW'(in_onset_value);
        end
      end
      // Early errors, or start the mean division on |sum| / n.
      ate_pkg::S_CHECK: begin
        otempo_nxt = '0;
        oconf_nxt  = '0;
        olag_nxt   = '0;
        if (count_r < CW'(ate_pkg::MIN_SAMPLES)) begin
          ost_nxt = ate_pkg::ST_FEW;
        end else if (bad_cfg) begin
          ost_nxt = ate_pkg::ST_CFG;
        end
        dquo_nxt = DW'(sum_r[SW-1] ? -sum_r : sum_r);
        dden_nxt = EW'(count_r);
        drem_nxt = '0;
        dcnt_nxt = DCW'(DW);
      end
      // One quotient bit per cycle.
      ate_pkg::S_DIV: begin
        drem_nxt = rem_ge ? (rem_sh - {1'b0, dden_r}) : rem_sh;
        dquo_nxt = {dquo_r[DW-2:0], rem_ge};
        dcnt_nxt = dcnt_r - DCW'(1);
      end
      // Floored mean: round toward minus infinity for a negative sum.
      ate_pkg::S_MEAN: begin
        if (sum_r[SW-1]) begin
          mean_nxt = -($signed(dquo_r[SB:0]) + $signed((SB+1)'(rem_nz)));
        end else begin
          mean_nxt = $signed(dquo_r[SB:0]);
        end
        idx_nxt    = '0;
        energy_nxt = '0;
      end
      ate_pkg::S_EN_B: a_nxt = rect_v;
      // Energy accumulation.
      ate_pkg::S_EN_D: begin
        energy_nxt = energy_r + EW'(prod_r);
        idx_nxt    = idx_r + CW'(1);
      end
      // Energy check, then lo = 60*rate / (16*max).
      ate_pkg::S_EN_CHK: begin
        ost_nxt  = ate_pkg::ST_NOEN;
        dquo_nxt = DW'(WW'(rate_r) * WW'(ate_pkg::SEC_PER_MIN));
        dden_nxt = EW'({max_r, 4'b0});
        drem_nxt = '0;
        dcnt_nxt = DCW'(DW);
      end
      // Keep lo (at least one), then hi = ceil(60*rate / (16*min)).
      ate_pkg::S_LO: begin
        lo_nxt   = (dquo_r[WW-1:0] == '0) ? WW'(1) : dquo_r[WW-1:0];
        dquo_nxt = DW'(WW'(rate_r) * WW'(ate_pkg::SEC_PER_MIN));
        dden_nxt = EW'({min_r, 4'b0});
        drem_nxt = '0;
        dcnt_nxt = DCW'(DW);
      end
      // Clamp the window and start the lag search.
      ate_pkg::S_WIN: begin
        ost_nxt      = ate_pkg::ST_EMPTY;
        hi_nxt       = CW'(hi_clamp);
        lag_nxt      = CW'(lo_r);
        idx_nxt      = CW'(lo_r);
        acc_nxt      = '0;
        best_nxt     = '0;
        best_lag_nxt = '0;
      end
      ate_pkg::S_AC_B: a_nxt = rect_v;
      ate_pkg::S_AC_D: begin
        acc_nxt = acc_r + EW'(prod_r);
        idx_nxt = idx_r + CW'(1);
      end
      // Strictly larger score wins, so ties keep the smaller lag.
      ate_pkg::S_AC_NEXT: begin
        if (acc_r > best_r) begin
          best_nxt     = acc_r;
          best_lag_nxt = lag_r;
        end
        lag_nxt = lag_r + CW'(1);
        idx_nxt = lag_r + CW'(1);
        acc_nxt = '0;
      end
      // Weak peak check, then tempo = 240*rate / lag.
      ate_pkg::S_PEAK: begin
        ost_nxt  = ate_pkg::ST_WEAK;
        dquo_nxt = DW'(TW'(rate_r) * TW'(ate_pkg::TEMPO_MUL));
        dden_nxt = EW'(best_lag_r);
        drem_nxt = '0;
        dcnt_nxt = DCW'(DW);
      end
      // Saturate tempo, then confidence = (score << 16) / energy.
      ate_pkg::S_TEMPO: begin
        otempo_nxt = (dquo_r > DW'(ate_pkg::OUT_MAX)) ? ate_pkg::OUT_MAX
                                                       : dquo_r[ate_pkg::OUT_W-1:0];
        dquo_nxt   = {best_r, 16'b0};
        dden_nxt   = energy_r;
        drem_nxt   = '0;
        dcnt_nxt   = DCW'(DW);
      end
      ate_pkg::S_CONF: begin
        oconf_nxt = (dquo_r > DW'(ate_pkg::OUT_MAX)) ? ate_pkg::OUT_MAX
                                                      : dquo_r[ate_pkg::OUT_W-1:0];
        olag_nxt  = ate_pkg::LAG_W'(best_lag_r);
        ost_nxt   = ate_pkg::ST_OK;
      end
      ate_pkg::S_OUT: begin
        run_clear = out_acc;
      end
      default: ;
    endcase

    // Error exits leave zero payload.
    if (state_nxt == ate_pkg::S_OUT && state_r != ate_pkg::S_OUT &&
        state_r != ate_pkg::S_CONF) begin
      otempo_nxt = '0;
      oconf_nxt  = '0;
      olag_nxt   = '0;
    end

    // A delivered result starts a new curve.
    if (run_clear) begin
      count_nxt    = '0;
      sum_nxt      = '0;
      energy_nxt   = '0;
      best_nxt     = '0;
      best_lag_nxt = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ate_pkg::S_LOAD;
      ret_r      <= ate_pkg::S_LOAD;
      rate_r     <= ate_pkg::RATE_RST;
      min_r      <= ate_pkg::MIN_RST;
      max_r      <= ate_pkg::MAX_RST;
      count_r    <= '0;
      sum_r      <= '0;
      energy_r   <= '0;
      best_r     <= '0;
      best_lag_r <= '0;
      dcnt_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      ret_r      <= ret_nxt;
      rate_r     <= rate_nxt;
      min_r      <= min_nxt;
      max_r      <= max_nxt;
      count_r    <= count_nxt;
      sum_r      <= sum_nxt;
      energy_r   <= energy_nxt;
      best_r     <= best_nxt;
      best_lag_r <= best_lag_nxt;
      dcnt_r     <= dcnt_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    idx_r    <= idx_nxt;
    lag_r    <= lag_nxt;
    hi_r     <= hi_nxt;
    lo_r     <= lo_nxt;
    mean_r   <= mean_nxt;
    a_r      <= a_nxt;
    prod_r   <= prod_nxt;
    dquo_r   <= dquo_nxt;
    drem_r   <= drem_nxt;
    dden_r   <= dden_nxt;
    ost_r    <= ost_nxt;
    otempo_r <= otempo_nxt;
    oconf_r  <= oconf_nxt;
    olag_r   <= olag_nxt;
  end

endmodule

### tb/testbench.sv
// Self-checking testbench for the autocorrelation tempo estimator.
// Drives onset curves and register writes, predicts each result in SystemVerilog and
// compares it field by field. Depends on ate_pkg and the estimator RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CURVE_DEPTH = 1024;
  localparam int STALL_LIMIT = 200000;

  typedef struct packed {
    logic [ate_pkg::STATUS_W-1:0] status;
    logic [ate_pkg::OUT_W-1:0]    tempo;
    logic [ate_pkg::OUT_W-1:0]    conf;
    logic [ate_pkg::LAG_W-1:0]    lag;
  } tempo_result_t;

  typedef enum int {PAT_CONST, PAT_ALT, PAT_PULSE, PAT_SPIKE} curve_shape_t;

  typedef struct {
    int            len;
    curve_shape_t  shape;
    int            level;
    bit            typed;
    tempo_result_t want;
  } curve_row_t;

  typedef struct {
    logic [ate_pkg::RATE_W-1:0] rate;
    logic [ate_pkg::BPM_W-1:0]  lo_bpm;
    logic [ate_pkg::BPM_W-1:0]  hi_bpm;
    int                         curves;
  } setting_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic signed [15:0]             in_onset_value = '0;
  logic                           in_last_sample = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [ate_pkg::STATUS_W-1:0]   out_status;
  logic [ate_pkg::OUT_W-1:0]      out_tempo_bpm_q6;
  logic [ate_pkg::OUT_W-1:0]      out_confidence_q16;
  logic [ate_pkg::LAG_W-1:0]      out_best_lag;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [ate_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ate_pkg::RATE_W-1:0]     cfg_data = '0;

  // Predictor state: registers and the curve collected so far.
  logic [ate_pkg::RATE_W-1:0]     pred_rate = ate_pkg::RATE_RST;
  logic [ate_pkg::BPM_W-1:0]      pred_min = ate_pkg::MIN_RST;
  logic [ate_pkg::BPM_W-1:0]      pred_max = ate_pkg::MAX_RST;
  logic signed [15:0]             curve_mem [CURVE_DEPTH];
  int                             curve_len = 0;
  longint                         curve_sum = 0;

  tempo_result_t                  tempo_q[$];
  int                             mismatches = 0;
  int                             quiet_cycles = 0;
  int                             tx_pct = 0;
  int                             rx_pct = 0;

  autocorrelation_tempo_estimator i_dut (.*);

  always #5 clk = ~clk;

  // Receiver stall pattern.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_pct);
  end

  // Computes the result that closes the current curve.
  function automatic tempo_result_t estimate_tempo();
    tempo_result_t r;
    longint n, mean, energy, num, lo, hi, lag, i, s, best, best_lag, t, c;
    longint rv [CURVE_DEPTH];
    r = '0;
    n = curve_len;
    if (n < ate_pkg::MIN_SAMPLES) begin
      r.status = ate_pkg::ST_FEW;
      return r;
    end
    if (pred_rate == 0 || pred_min == 0 || pred_max <= pred_min) begin
      r.status = ate_pkg::ST_CFG;
      return r;
    end
    if (curve_sum >= 0) mean = curve_sum / n;
    else mean = -((-curve_sum + n - 1) / n);
    energy = 0;
    for (i = 0; i < n; i++) begin
      rv[i] = curve_mem[i] - mean;
      if (rv[i] < 0) rv[i] = 0;
      energy += rv[i] * rv[i];
    end
    if (energy == 0) begin
      r.status = ate_pkg::ST_NOEN;
      return r;
    end
    num = ate_pkg::SEC_PER_MIN * longint'(pred_rate);
    lo = num / (16 * longint'(pred_max));
    if (lo < 1) lo = 1;
    hi = (num + 16 * longint'(pred_min) - 1) / (16 * longint'(pred_min));
    if (hi > n - 1) hi = n - 1;
    if (hi <= lo) begin
      r.status = ate_pkg::ST_EMPTY;
      return r;
    end
    best = 0;
    best_lag = 0;
    for (lag = lo; lag <= hi; lag++) begin
      s = 0;
      for (i = lag; i < n; i++) s += rv[i] * rv[i - lag];
      if (s > best) begin
        best = s;
        best_lag = lag;
      end
    end
    if (best_lag == 0 || best * ate_pkg::WEAK_MUL <= energy) begin
      r.status = ate_pkg::ST_WEAK;
      return r;
    end
    t = (ate_pkg::TEMPO_MUL * longint'(pred_rate)) / best_lag;
    c = (best << 16) / energy;
    r.status = ate_pkg::ST_OK;
    r.tempo = (t > ate_pkg::OUT_MAX) ? ate_pkg::OUT_MAX : t[ate_pkg::OUT_W-1:0];
    r.conf = (c > ate_pkg::OUT_MAX) ? ate_pkg::OUT_MAX : c[ate_pkg::OUT_W-1:0];
    r.lag = best_lag[ate_pkg::LAG_W-1:0];
    return r;
  endfunction

  // Sends one sample request and updates the predictor when it is taken.
  task automatic send_sample(input logic signed [15:0] v, input bit last, input bit typed,
                             input tempo_result_t want);
    tempo_result_t r;
    if ($urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_onset_value <= v;
    in_last_sample <= last;
    do @(posedge clk); while (in_stall);
    if (curve_len < CURVE_DEPTH) begin
      curve_mem[curve_len] = v;
      curve_len++;
      curve_sum += v;
    end
    if (last) begin
      r = estimate_tempo();
      tempo_q.push_back(typed ? want : r);
      curve_len = 0;
      curve_sum = 0;
    end
  endtask

  // Waits until every result is back, then writes one register.
  task automatic write_reg(input logic [ate_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ate_pkg::RATE_W-1:0] d);
    in_valid <= 1'b0;
    while (tempo_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      ate_pkg::REG_RATE: pred_rate = d;
      ate_pkg::REG_MIN:  pred_min = d[ate_pkg::BPM_W-1:0];
      ate_pkg::REG_MAX:  pred_max = d[ate_pkg::BPM_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic signed [15:0] clip16(input int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] shape_value(input curve_shape_t shape,
                                                     input int level, input int idx);
    case (shape)
      PAT_ALT:   return (idx % 2 == 0) ? 16'sh7FFF : 16'sh8000;
      PAT_PULSE: return (idx % 4 == 0) ? clip16(level) : 16'sd0;
      PAT_SPIKE: return (idx == 0) ? clip16(level) : 16'sd0;
      default:   return clip16(level);
    endcase
  endfunction

  // Random curve: mostly periodic pulses with noise, some full-range noise, single spikes or flat curves.
  task automatic send_random_curve();
    int n, kind, per, amp, base, i;
    logic signed [15:0] v;
    n = ($urandom_range(9) == 0) ? $urandom_range(1, 7) : $urandom_range(8, 24);
    kind = $urandom_range(9);
    per = $urandom_range(2, 12);
    amp = $urandom_range(1, 65535) - 32768;
    base = $urandom_range(0, 65535) - 32768;
    for (i = 0; i < n; i++) begin
      if (kind <= 6)
        v = (i % per == 0) ? clip16(amp) : clip16(base / 8 + $urandom_range(0, 63) - 32);
      else if (kind == 7) v = 16'($urandom);
      else if (kind == 8) v = (i == 0) ? clip16(amp) : 16'sd0;
      else v = clip16(base);
      send_sample(v, i == n - 1, 1'b0, '0);
    end
  endtask

  // Scoreboard: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    tempo_result_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_status, out_tempo_bpm_q6, out_confidence_q16, out_best_lag};
      if (tempo_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: %p", got);
      end else begin
        want = tempo_q.pop_front();
        if (got.status !== want.status || got.tempo !== want.tempo ||
            got.conf !== want.conf || got.lag !== want.lag) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted request.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    curve_row_t rows [$];
    setting_t   plan [$];
    int total, done, k, i;
    // Directed curves at reset settings: too short, flat, empty lag window.
    rows.push_back('{1, PAT_CONST, 32767, 1'b1, '{ate_pkg::ST_FEW, 16'd0, 16'd0, 10'd0}});
    rows.push_back('{7, PAT_ALT, 0, 1'b1, '{ate_pkg::ST_FEW, 16'd0, 16'd0, 10'd0}});
    rows.push_back('{8, PAT_CONST, -32768, 1'b1, '{ate_pkg::ST_NOEN, 16'd0, 16'd0, 10'd0}});
    rows.push_back('{10, PAT_ALT, 0, 1'b1, '{ate_pkg::ST_EMPTY, 16'd0, 16'd0, 10'd0}});
    // Settings walked by the random part, extremes and bad settings among them.
    plan.push_back('{16'd1376, 10'd60, 10'd200, 2});
    plan.push_back('{16'd160, 10'd60, 10'd300, 4});
    plan.push_back('{16'd1, 10'd1, 10'd1000, 3});
    plan.push_back('{16'd65535, 10'd1, 10'd1000, 2});
    plan.push_back('{16'd0, 10'd60, 10'd200, 1});
    plan.push_back('{16'd160, 10'd300, 10'd300, 1});
    plan.push_back('{16'd500, 10'd0, 10'd1000, 1});
    plan.push_back('{16'd160, 10'd40, 10'd120, 4});
    plan.push_back('{16'd160, 10'd60, 10'd300, 4});

    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[r]) begin
      for (i = 0; i < rows[r].len; i++)
        send_sample(shape_value(rows[r].shape, rows[r].level, i), i == rows[r].len - 1,
                    rows[r].typed, rows[r].want);
    end

    // Long curves at the reset settings reach the lag search there.
    for (k = 0; k < 2; k++) begin
      for (i = 0; i < 40; i++)
        send_sample(shape_value(PAT_PULSE, 20000 + k * 5000, i + k), i == 39, 1'b0, '0);
    end

    total = 0;
    foreach (plan[q]) total += plan[q].curves;
    done = 0;
    foreach (plan[q]) begin
      write_reg(ate_pkg::REG_RATE, plan[q].rate);
      write_reg(ate_pkg::REG_MIN, {6'd0, plan[q].lo_bpm});
      write_reg(ate_pkg::REG_MAX, {6'd0, plan[q].hi_bpm});
      for (k = 0; k < plan[q].curves; k++) begin
        // Receiver stalls most first, then the sender idles most, then neither.
        if (done * 3 < total) begin
          tx_pct = 27;
          rx_pct = 69;
        end else if (done * 3 < total * 2) begin
          tx_pct = 69;
          rx_pct = 27;
        end else begin
          tx_pct = 0;
          rx_pct = 0;
        end
        send_random_curve();
        done++;
      end
    end

    in_valid <= 1'b0;
    while (tempo_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

### filelist.f
rtl/core/ate_pkg.sv
rtl/core/ate_ram.sv
rtl/core/autocorrelation_tempo_estimator.sv
tb/testbench.sv
